/* rtl/port_table_rate_limited_gateway_unit_defines.svh */
// assertion macros for the port table gateway
`ifndef PORT_TABLE_RATE_LIMITED_GATEWAY_UNIT_DEFINES_SVH
`define PORT_TABLE_RATE_LIMITED_GATEWAY_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PTRLG_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// trigger in one cycle implies the consequence in the next
`define PTRLG_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptrlg_pkg.sv */
// types and constants of the port table gateway
package ptrlg_pkg;

  // request opcodes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_UPLINK   = 2'd1;
  localparam logic [1:0] OP_DOWNLINK = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DELIVERED = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_NO_SINK   = 3'd2;
  localparam logic [2:0] ST_RATE_LIM  = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;
  localparam logic [2:0] ST_ADDED     = 3'd5;
  localparam logic [2:0] ST_DUPLICATE = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  // fixed rate window in ms
  localparam logic [31:0] WINDOW_MS = 32'd1000;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 256;

  // one port table entry as kept in memory
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  kind;
    logic        has_tx;
    logic [15:0] cap;
    logic [15:0] count;
    logic [31:0] wstart;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

endpackage

/* rtl/port_table_rate_limited_gateway_unit.sv */
// port table gateway with fixed-window uplink rate limiting
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata item fields, tuser opcode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata result fields, tuser status
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i uplink_enabled
//
// a request scans every table slot before its result is loaded into the result register,
// one table slot read per scan cycle; a new request is taken only once the block is back in idle
// the no-op opcode is taken without a scan and gives no result
// reset clears the slot valid bits, counters, sequence and config at once;
// entries of unused slots are ignored, so the table memory needs no clearing pass
// a stalled result holds in the output register; the next request scans, then waits
`include "port_table_rate_limited_gateway_unit_defines.svh"

module port_table_rate_limited_gateway_unit
  import ptrlg_pkg::*;
#(
  parameter int PORT_SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // port_id, now_ms, win_cap, port_kind, has_transmit, peer_addr, length,
  // rssi, payload_ref, sink_accepts, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_port_id, out_kind, sequence_res, out_addr, out_length, out_rssi,
  // out_payload_ref, up_pass_cnt, up_drop_cnt, dn_pass_cnt, dn_drop_cnt
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [2:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);

  localparam int IDX_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PORT_SLOTS - 1);

  state_e state_q, state_d;

  // held request
  logic [IN_DATA_W-1:0] item_q;
  logic [1:0]           op_q;

  logic [7:0]  in_pid;
  logic [31:0] in_now;
  logic [15:0] in_cap;
  logic [7:0]  in_kind;
  logic        in_tx;
  logic [15:0] in_addr;
  logic [15:0] in_len;
  logic [15:0] in_rssi;
  logic [31:0] in_pref;
  logic        in_accepts;

  assign in_pid     = item_q[7:0];
  assign in_now     = item_q[39:8];
  assign in_cap     = item_q[55:40];
  assign in_kind    = item_q[63:56];
  assign in_tx      = item_q[64];
  assign in_addr    = item_q[80:65];
  assign in_len     = item_q[96:81];
  assign in_rssi    = item_q[112:97];
  assign in_pref    = item_q[144:113];
  assign in_accepts = item_q[145];

  // table storage: valid bits in flops, entries in a synchronous memory
  logic [PORT_SLOTS-1:0] used_q;
  entry_t                mem_q [PORT_SLOTS];
  entry_t                rd_data_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  entry_t                mem_wdata;

  // scan state
  logic [IDX_W-1:0] chk_q;
  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_slot_q, free_slot_q;
  entry_t           hit_entry_q;
  logic             slot_hit, slot_free;

  // architectural state outside the table
  logic        uplink_en_q;
  logic [31:0] seq_q, seq_d;
  logic [31:0] up_pub_q, up_pub_d, up_drop_q, up_drop_d;
  logic [31:0] dn_sent_q, dn_sent_d, dn_drop_q, dn_drop_d;

  // result register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [2:0]            m_status_q;

  logic s_acc, out_load;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uplink_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      uplink_en_q <= cfg_data_i;
    end
  end

  // read address: slot 0 on acceptance, then the slot after the one checked
  always_comb begin
    rd_addr = '0;
    if (state_q == S_SCAN && chk_q != LAST_IDX) begin
      rd_addr = IDX_W'(chk_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // slot under check against the held id
  assign slot_hit  = used_q[chk_q] && (rd_data_q.id == in_pid) && !hit_q;
  assign slot_free = !used_q[chk_q] && !free_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && s_axis_tuser != OP_NONE) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_q == LAST_IDX) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chk_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_acc) begin
        chk_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (chk_q != LAST_IDX) begin
          chk_q <= IDX_W'(chk_q + 1'b1);
        end
        if (slot_hit) begin
          hit_q <= 1'b1;
        end
        if (slot_free) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q <= s_axis_tdata;
      op_q   <= s_axis_tuser;
    end
    if (state_q == S_SCAN) begin
      if (slot_hit) begin
        hit_slot_q  <= chk_q;
        hit_entry_q <= rd_data_q;
      end
      if (slot_free) begin
        free_slot_q <= chk_q;
      end
    end
  end

  // update step
  logic [31:0] elapsed;
  logic        win_expired, limited;
  logic [15:0] cnt_eff;
  logic [31:0] ws_eff;
  logic [2:0]  res_status;
  logic [7:0]  res_kind;
  logic [31:0] res_seq;
  logic [15:0] res_addr, res_len, res_rssi;
  logic [31:0] res_pref;
  logic        set_used;

  always_comb begin
    elapsed     = in_now - hit_entry_q.wstart;
    win_expired = (elapsed >= WINDOW_MS);
    cnt_eff     = win_expired ? 16'd0 : hit_entry_q.count;
    ws_eff      = win_expired ? in_now : hit_entry_q.wstart;
    limited     = (cnt_eff >= hit_entry_q.cap);

    res_status = ST_UNKNOWN;
    res_kind   = 8'd0;
    res_seq    = 32'd0;
    res_addr   = 16'd0;
    res_len    = 16'd0;
    res_rssi   = 16'd0;
    res_pref   = 32'd0;
    mem_we     = 1'b0;
    mem_waddr  = hit_slot_q;
    mem_wdata  = hit_entry_q;
    set_used   = 1'b0;
    seq_d      = seq_q;
    up_pub_d   = up_pub_q;
    up_drop_d  = up_drop_q;
    dn_sent_d  = dn_sent_q;
    dn_drop_d  = dn_drop_q;

    case (op_q)
      OP_ADD: begin
        res_kind = in_kind;
        if (hit_q) begin
          res_status = ST_DUPLICATE;
        end else if (free_q) begin
          res_status = ST_ADDED;
          mem_we     = out_load;
          set_used   = out_load;
          mem_waddr  = free_slot_q;
          mem_wdata  = '{id: in_pid, kind: in_kind, has_tx: in_tx, cap: in_cap,
                         count: 16'd0, wstart: 32'd0};
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_UPLINK: begin
        res_addr = in_addr;
        res_len  = in_len;
        res_rssi = in_rssi;
        res_pref = in_pref;
        if (!hit_q) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_kind = hit_entry_q.kind;
          if (!uplink_en_q) begin
            res_status = ST_NO_SINK;
          end else if (hit_entry_q.cap != 16'd0 && limited) begin
            // window restart is still kept
            res_status       = ST_RATE_LIM;
            mem_we           = out_load;
            mem_wdata.wstart = ws_eff;
            mem_wdata.count  = cnt_eff;
          end else begin
            if (hit_entry_q.cap != 16'd0) begin
              mem_we           = out_load;
              mem_wdata.wstart = ws_eff;
              mem_wdata.count  = cnt_eff + 16'd1;
            end
            res_seq    = seq_q;
            seq_d      = seq_q + 32'd1;
            res_status = in_accepts ? ST_DELIVERED : ST_REFUSED;
          end
        end
        if (res_status == ST_DELIVERED) begin
          up_pub_d = up_pub_q + 32'd1;
        end else begin
          up_drop_d = up_drop_q + 32'd1;
        end
      end
      default: begin
        // downlink
        res_addr = in_addr;
        res_len  = in_len;
        res_pref = in_pref;
        if (!hit_q) begin
          res_status = ST_UNKNOWN;
        end else if (!hit_entry_q.has_tx) begin
          res_status = ST_NO_SINK;
        end else begin
          res_status = in_accepts ? ST_DELIVERED : ST_REFUSED;
        end
        if (res_status == ST_DELIVERED) begin
          dn_sent_d = dn_sent_q + 32'd1;
        end else begin
          dn_drop_d = dn_drop_q + 32'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      seq_q     <= 32'd0;
      up_pub_q  <= 32'd0;
      up_drop_q <= 32'd0;
      dn_sent_q <= 32'd0;
      dn_drop_q <= 32'd0;
      m_valid_q <= 1'b0;
    end else begin
      if (set_used) begin
        used_q[mem_waddr] <= 1'b1;
      end
      if (out_load) begin
        seq_q     <= seq_d;
        up_pub_q  <= up_pub_d;
        up_drop_q <= up_drop_d;
        dn_sent_q <= dn_sent_d;
        dn_drop_q <= dn_drop_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status;
      m_data_q   <= {dn_drop_d, dn_sent_d, up_drop_d, up_pub_d, res_pref, res_rssi,
                     res_len, res_addr, res_seq, res_kind, in_pid};
    end
  end

  // table is written only in the update step, never while a scan reads it
  `PTRLG_ASSERT(a_no_write_in_scan, !(mem_we && state_q != S_EXEC), "table write outside update")
  // a real request always starts a table walk
  `PTRLG_ASSERT_NEXT(a_acc_scans, s_acc && s_axis_tuser != OP_NONE, state_q == S_SCAN,
                     "accepted request did not start a scan")
  // sequence advances by at most one per cycle
  `PTRLG_ASSERT_NEXT(a_seq_step, 1'b1, seq_q == $past(seq_q) || seq_q == $past(seq_q) + 32'd1,
                     "sequence jumped")
  // an added result always comes with the table write
  `PTRLG_ASSERT(a_add_writes, !(out_load && res_status == ST_ADDED) || (mem_we && set_used),
                "add result without table write")

endmodule

/* tb/port_table_rate_limited_gateway_unit_tb.sv */
// self-checking testbench for the port table gateway: predicts every result and compares it
`timescale 1ns / 1ps

module port_table_rate_limited_gateway_unit_tb
  import ptrlg_pkg::*;
();

  localparam int PORT_SLOTS   = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT        = 300000;
  localparam int ID_POOL      = 12;

  // one request as the sender sees it
  typedef struct {
    logic [1:0]         opcode;
    logic [7:0]         port_id;
    logic [31:0]        now_ms;
    logic [15:0]        win_cap;
    logic [7:0]         port_kind;
    logic               has_tx;
    logic [15:0]        peer_addr;
    logic [15:0]        length;
    logic signed [15:0] rssi;
    logic [31:0]        payload_ref;
    logic               sink_accepts;
  } req_t;

  // one frame envelope or drop result
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  port_id;
    logic [7:0]  kind;
    logic [31:0] seq;
    logic [15:0] addr;
    logic [15:0] length;
    logic [15:0] rssi;
    logic [31:0] pref;
    logic [31:0] up_pub;
    logic [31:0] up_drop;
    logic [31:0] dn_sent;
    logic [31:0] dn_drop;
  } res_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = OP_NONE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_data_i    = 1'b0;

  // shadow of the gateway state
  logic        tbl_used   [PORT_SLOTS];
  logic [7:0]  tbl_id     [PORT_SLOTS];
  logic [7:0]  tbl_kind   [PORT_SLOTS];
  logic        tbl_has_tx [PORT_SLOTS];
  logic [15:0] tbl_cap    [PORT_SLOTS];
  logic [15:0] tbl_count  [PORT_SLOTS];
  logic [31:0] tbl_wstart [PORT_SLOTS];
  logic [31:0] next_seq;
  logic [31:0] cnt_up_pub, cnt_up_drop, cnt_dn_sent, cnt_dn_drop;
  logic        cfg_uplink_en;

  req_t item_q[$];
  res_t envelope_q[$];
  req_t drive_item;
  res_t mon_got, mon_want;
  bit   req_fired = 1'b0;

  int n_queued = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int n_noop = 0, n_cfg = 0, cyc = 0;
  int send_idle_pct = 0, recv_idle_pct = 0, hold_left = 0;
  int status_seen[8];
  logic [31:0] sim_ms = '0;
  logic [7:0]  id_pool[ID_POOL] = '{8'h00, 8'hFF, 8'h5A, 8'h01, 8'h02, 8'h03,
                                    8'h04, 8'h05, 8'h06, 8'h07, 8'h80, 8'hFE};

  port_table_rate_limited_gateway_unit #(
    .PORT_SLOTS(PORT_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // timeout guard
  always @(posedge clk_i) begin
    cyc++;
    if (cyc == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cyc, envelope_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // works out the result of one accepted request and advances the shadow state
  task automatic predict_envelope(input req_t r);
    res_t        e;
    int          slot;
    int          i;
    logic [31:0] delta;
    bit          limited;
    e = '{default: '0};
    slot = -1;
    limited = 1'b0;
    if (r.opcode == OP_NONE) begin
      n_noop++;
      return;
    end
    e.port_id = r.port_id;
    for (i = 0; i < PORT_SLOTS; i++)
      if (slot < 0 && tbl_used[i] && tbl_id[i] == r.port_id) slot = i;
    case (r.opcode)
      OP_ADD: begin
        e.kind = r.port_kind;
        if (slot >= 0) begin
          e.status = ST_DUPLICATE;
        end else begin
          // lowest free slot wins
          e.status = ST_FULL;
          for (i = 0; i < PORT_SLOTS; i++) begin
            if (e.status == ST_FULL && !tbl_used[i]) begin
              tbl_used[i]   = 1'b1;
              tbl_id[i]     = r.port_id;
              tbl_kind[i]   = r.port_kind;
              tbl_has_tx[i] = r.has_tx;
              tbl_cap[i]    = r.win_cap;
              tbl_count[i]  = '0;
              tbl_wstart[i] = '0;
              e.status      = ST_ADDED;
            end
          end
        end
      end
      OP_UPLINK: begin
        e.addr   = r.peer_addr;
        e.length = r.length;
        e.rssi   = r.rssi;
        e.pref   = r.payload_ref;
        if (slot < 0) begin
          e.status = ST_UNKNOWN;
        end else begin
          e.kind = tbl_kind[slot];
          if (!cfg_uplink_en) begin
            e.status = ST_NO_SINK;
          end else begin
            // fixed window, a zero cap never limits
            if (tbl_cap[slot] != 0) begin
              delta = r.now_ms - tbl_wstart[slot];
              if (delta >= WINDOW_MS) begin
                tbl_wstart[slot] = r.now_ms;
                tbl_count[slot]  = '0;
              end
              if (tbl_count[slot] >= tbl_cap[slot]) limited = 1'b1;
              else tbl_count[slot] = tbl_count[slot] + 16'd1;
            end
            if (limited) begin
              e.status = ST_RATE_LIM;
            end else begin
              // a refused frame still takes its sequence number
              e.seq    = next_seq;
              next_seq = next_seq + 32'd1;
              e.status = r.sink_accepts ? ST_DELIVERED : ST_REFUSED;
            end
          end
        end
        if (e.status == ST_DELIVERED) cnt_up_pub = cnt_up_pub + 32'd1;
        else cnt_up_drop = cnt_up_drop + 32'd1;
      end
      OP_DOWNLINK: begin
        e.addr   = r.peer_addr;
        e.length = r.length;
        e.pref   = r.payload_ref;
        if (slot < 0) e.status = ST_UNKNOWN;
        else if (!tbl_has_tx[slot]) e.status = ST_NO_SINK;
        else e.status = r.sink_accepts ? ST_DELIVERED : ST_REFUSED;
        if (e.status == ST_DELIVERED) cnt_dn_sent = cnt_dn_sent + 32'd1;
        else cnt_dn_drop = cnt_dn_drop + 32'd1;
      end
      default: ;
    endcase
    e.up_pub  = cnt_up_pub;
    e.up_drop = cnt_up_drop;
    e.dn_sent = cnt_dn_sent;
    e.dn_drop = cnt_dn_drop;
    envelope_q.push_back(e);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // request with random payload fields; callers override what they need
  function automatic req_t payload_item(input logic [1:0] op, input logic [7:0] id);
    req_t r;
    r.opcode       = op;
    r.port_id      = id;
    r.now_ms       = sim_ms;
    r.win_cap      = 16'($urandom_range(4, 1));
    r.port_kind    = 8'($urandom);
    r.has_tx       = 1'($urandom);
    r.peer_addr    = 16'($urandom);
    r.length       = 16'($urandom);
    r.rssi         = 16'($urandom);
    r.payload_ref  = $urandom;
    r.sink_accepts = ($urandom_range(99) < 80);
    return r;
  endfunction

  // random request, mostly on ports that exist so the rate windows get exercised
  function automatic req_t random_item();
    req_t        r;
    int          pick;
    logic [1:0]  op;
    logic [7:0]  id;
    pick = $urandom_range(99);
    if (pick < 10) op = OP_ADD;
    else if (pick < 62) op = OP_UPLINK;
    else if (pick < 95) op = OP_DOWNLINK;
    else op = OP_NONE;
    if ($urandom_range(99) < 85) id = id_pool[$urandom_range(ID_POOL - 1)];
    else id = 8'($urandom_range(255));
    // time crawls forward, with an odd jump anywhere including across the wrap
    if ($urandom_range(49) == 0) sim_ms = $urandom;
    else sim_ms = sim_ms + $urandom_range(40);
    r = payload_item(op, id);
    if ($urandom_range(9) == 0) r.win_cap = 16'($urandom);
    else if ($urandom_range(9) == 0) r.win_cap = '0;
    return r;
  endfunction

  task automatic push_item(input req_t r);
    item_q.push_back(r);
    n_queued++;
  endtask

  // wait for every request to be taken and every result to come back
  task automatic wait_quiet();
    while (n_accepted != n_queued || envelope_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_uplink_enable(input logic en);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_uplink_en = en;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_chunk(input int count, input int s_idle, input int r_idle,
                           input logic en);
    int k;
    wait_quiet();
    write_uplink_enable(en);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (k = 0; k < count; k++) push_item(random_item());
  endtask

  // request driver, holds a request until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_fired) begin
      req_fired = 1'b0;
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = item_q.pop_front();
        s_axis_tuser  <= drive_item.opcode;
        s_axis_tdata  <= {6'b0, drive_item.sink_accepts, drive_item.payload_ref,
                          drive_item.rssi, drive_item.length, drive_item.peer_addr,
                          drive_item.has_tx, drive_item.port_kind, drive_item.win_cap,
                          drive_item.now_ms, drive_item.port_id};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // request acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_envelope(drive_item);
      n_accepted++;
      req_fired = 1'b1;
    end
  end

  // result side ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (envelope_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got status %0h data %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        n_errors++;
      end else begin
        mon_want = envelope_q.pop_front();
        mon_got.status  = m_axis_tuser;
        mon_got.port_id = m_axis_tdata[7:0];
        mon_got.kind    = m_axis_tdata[15:8];
        mon_got.seq     = m_axis_tdata[47:16];
        mon_got.addr    = m_axis_tdata[63:48];
        mon_got.length  = m_axis_tdata[79:64];
        mon_got.rssi    = m_axis_tdata[95:80];
        mon_got.pref    = m_axis_tdata[127:96];
        mon_got.up_pub  = m_axis_tdata[159:128];
        mon_got.up_drop = m_axis_tdata[191:160];
        mon_got.dn_sent = m_axis_tdata[223:192];
        mon_got.dn_drop = m_axis_tdata[255:224];
        status_seen[mon_want.status]++;
        compare_field("status", 32'(mon_want.status), 32'(mon_got.status));
        compare_field("port_id", 32'(mon_want.port_id), 32'(mon_got.port_id));
        compare_field("kind", 32'(mon_want.kind), 32'(mon_got.kind));
        compare_field("sequence", mon_want.seq, mon_got.seq);
        compare_field("addr", 32'(mon_want.addr), 32'(mon_got.addr));
        compare_field("length", 32'(mon_want.length), 32'(mon_got.length));
        compare_field("rssi", 32'(mon_want.rssi), 32'(mon_got.rssi));
        compare_field("payload_ref", mon_want.pref, mon_got.pref);
        compare_field("up_pass_cnt", mon_want.up_pub, mon_got.up_pub);
        compare_field("up_drop_cnt", mon_want.up_drop, mon_got.up_drop);
        compare_field("dn_pass_cnt", mon_want.dn_sent, mon_got.dn_sent);
        compare_field("dn_drop_cnt", mon_want.dn_drop, mon_got.dn_drop);
      end
    end
  end

  initial begin
    req_t r;
    int   i;
    for (i = 0; i < PORT_SLOTS; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_id[i]     = '0;
      tbl_kind[i]   = '0;
      tbl_has_tx[i] = 1'b0;
      tbl_cap[i]    = '0;
      tbl_count[i]  = '0;
      tbl_wstart[i] = '0;
    end
    for (i = 0; i < 8; i++) status_seen[i] = 0;
    next_seq      = '0;
    cnt_up_pub    = '0;
    cnt_up_drop   = '0;
    cnt_dn_sent   = '0;
    cnt_dn_drop   = '0;
    cfg_uplink_en = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 82;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sink off: table building, unknown ports, downlink paths
    write_uplink_enable(1'b0);
    r = payload_item(OP_ADD, 8'h00);
    r.win_cap = '0; r.port_kind = 8'h00; r.has_tx = 1'b0;
    push_item(r);
    r = payload_item(OP_ADD, 8'hFF);
    r.win_cap = 16'd1; r.port_kind = 8'hFF; r.has_tx = 1'b1;
    push_item(r);
    push_item(r);  // same id again is a duplicate
    r = payload_item(OP_ADD, 8'h5A);
    r.win_cap = 16'hFFFF; r.port_kind = 8'hA5; r.has_tx = 1'b1;
    push_item(r);
    push_item(payload_item(OP_UPLINK, 8'h00));  // no sink installed
    push_item(payload_item(OP_UPLINK, 8'h07));  // unknown port
    push_item(payload_item(OP_DOWNLINK, 8'h07));
    push_item(payload_item(OP_DOWNLINK, 8'h00));  // port without transmitter
    r = payload_item(OP_DOWNLINK, 8'hFF);
    r.sink_accepts = 1'b0;
    push_item(r);
    r = payload_item(OP_DOWNLINK, 8'hFF);
    r.sink_accepts = 1'b1; r.peer_addr = 16'hFFFF; r.length = 16'hFFFF;
    r.payload_ref = 32'hFFFF_FFFF;
    push_item(r);
    push_item(payload_item(OP_NONE, 8'hFF));  // unused opcode, no result

    // sink on: unlimited port, then the cap-of-one window on port ff
    wait_quiet();
    write_uplink_enable(1'b1);
    r = payload_item(OP_UPLINK, 8'h00);
    r.sink_accepts = 1'b1; r.rssi = 16'sh7FFF; r.peer_addr = '0; r.length = '0;
    r.payload_ref = '0;
    push_item(r);
    r = payload_item(OP_UPLINK, 8'h00);
    r.sink_accepts = 1'b0; r.rssi = 16'sh8000;
    push_item(r);
    r = payload_item(OP_UPLINK, 8'hFF);
    r.now_ms = 32'd0; r.sink_accepts = 1'b1;
    push_item(r);
    r.now_ms = 32'd999;  // same window, cap reached
    push_item(r);
    r.now_ms = 32'd1000; r.sink_accepts = 1'b0;  // new window, refused but counted
    push_item(r);
    r.now_ms = 32'd1500; r.sink_accepts = 1'b1;
    push_item(r);
    r.now_ms = 32'hFFFF_FF00;
    push_item(r);
    r.now_ms = 32'h0000_0100;  // window spans the time wrap
    push_item(r);
    r = payload_item(OP_UPLINK, 8'h5A);
    r.now_ms = 32'hFFFF_FFFF;
    push_item(r);
    push_item(payload_item(OP_NONE, 8'h00));

    // random traffic in phases of idling and sink setting
    run_chunk(200, 9, 82, 1'b1);
    run_chunk(200, 82, 9, 1'b1);
    run_chunk(100, 0, 0, 1'b0);
    run_chunk(150, 0, 0, 1'b1);
    // receiver holds off while the sender keeps pushing: input must back up
    hold_left = 400;
    wait_quiet();
    run_chunk(150, 0, 0, 1'b1);
    wait_quiet();

    $display("covered %0d requests (%0d no-ops), %0d results, %0d sink setting writes",
             n_accepted, n_noop, n_results, n_cfg);
    $display("status mix: dlv %0d unk %0d nosink %0d rate %0d ref %0d add %0d dup %0d full %0d",
             status_seen[ST_DELIVERED], status_seen[ST_UNKNOWN], status_seen[ST_NO_SINK],
             status_seen[ST_RATE_LIM], status_seen[ST_REFUSED], status_seen[ST_ADDED],
             status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
    if (n_errors == 0 && envelope_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* port_table_rate_limited_gateway_unit.f */
+incdir+rtl
rtl/ptrlg_pkg.sv
rtl/port_table_rate_limited_gateway_unit.sv
tb/port_table_rate_limited_gateway_unit_tb.sv
